// ----- sv/qcp_pkg.sv -----
package qcp_pkg;

  // Edge command codes
  typedef enum logic [1:0] {
    CMD_LEFT_FALL  = 2'd0,
    CMD_RIGHT_FALL = 2'd1,
    CMD_LEFT_RISE  = 2'd2,
    CMD_RIGHT_RISE = 2'd3
  } cmd_e;

  localparam int unsigned LevelW    = 3;
  localparam int unsigned RowFieldW = 5;
  localparam int unsigned ColFieldW = 6;
  localparam int unsigned ColorW    = 8;

  localparam logic [LevelW-1:0] LevelMax   = 3'd5;
  localparam logic [ColorW-1:0] RedWeight  = 8'd36;
  localparam logic [ColorW-1:0] GrnWeight  = 8'd6;
  localparam logic [ColorW-1:0] ColorBase  = 8'd16;
  localparam logic [ColorW-1:0] ColorBlack = 8'd0;

  // Packed widths of the stream words
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;

  // One edge event
  typedef struct packed {
    logic              encoder_select;
    cmd_e              cmd;
    logic              partner_level;
    logic              draw_mode;
    logic              erase_mode;
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
  } edge_t;

  // One result word
  typedef struct packed {
    logic                 moved;
    logic [RowFieldW-1:0] cursor_row;
    logic [ColFieldW-1:0] cursor_col;
    logic                 write_enable;
    logic [ColorW-1:0]    write_color;
  } result_t;

  // Clamp a color level to the top of the 6-level cube
  function automatic logic [LevelW-1:0] level_sat(input logic [LevelW-1:0] lvl);
    level_sat = (lvl > LevelMax) ? LevelMax : lvl;
  endfunction

endpackage

// ----- sv/quadrature_cursor_painter.sv -----
// Quadrature cursor painter: takes one encoder edge word per cycle while the output is
// not held off by m_axis_tready_i, and returns one result word for each, in order.
// Each word passes an input register, then a result register; the step logic reads and
// updates the cursor and which-came-first flags as each word advances. Encoder 0 moves the
// column and encoder 1 the row, clamped to 0..COL_COUNT-1 and 0..ROW_COUNT-1; after
// reset the cursor sits at the center. Cursor fields are the low bits of the position.
module quadrature_cursor_painter #(
  parameter int unsigned ROW_COUNT = 32,
  parameter int unsigned COL_COUNT = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [0] partner_level, [1] draw_mode, [2] erase_mode, [5:3] red_level,
  // [8:6] green_level, [11:9] blue_level, [15:12] zero
  input  logic [qcp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] encoder_select, [2:1] cmd
  input  logic [qcp_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] moved, [5:1] cursor_row, [11:6] cursor_col, [12] write_enable,
  // [20:13] write_color, [23:21] zero
  output logic [qcp_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import qcp_pkg::*;

  logic    in_valid_q;
  edge_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t result;
  logic    advance;

  // Result register frees up when empty or being taken
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  qcp_step #(
    .ROW_COUNT(ROW_COUNT),
    .COL_COUNT(COL_COUNT)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .edge_i  (in_q),
    .result_o(result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.encoder_select <= s_axis_tuser_i[0];
      in_q.cmd            <= cmd_e'(s_axis_tuser_i[2:1]);
      in_q.partner_level  <= s_axis_tdata_i[0];
      in_q.draw_mode      <= s_axis_tdata_i[1];
      in_q.erase_mode     <= s_axis_tdata_i[2];
      in_q.red_level      <= s_axis_tdata_i[5:3];
      in_q.green_level    <= s_axis_tdata_i[8:6];
      in_q.blue_level     <= s_axis_tdata_i[11:9];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.write_color, out_q.write_enable,
                            out_q.cursor_col, out_q.cursor_row, out_q.moved};

  // A paint request only comes with a cursor step
  a_write_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_q.write_enable |-> out_q.moved)
    else $error("write requested without a cursor step");

  // No request means black
  a_idle_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_q.write_enable |-> out_q.write_color == ColorBlack)
    else $error("color set without a write request");

  // Saturated levels keep the color inside the 6x6x6 cube
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_q.write_color <= 8'd231)
    else $error("color outside the palette cube");

endmodule

// ----- sv/qcp_step.sv -----
module qcp_step #(
  parameter int unsigned ROW_COUNT = 32,
  parameter int unsigned COL_COUNT = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,   // commit the event held at edge_i
  input  qcp_pkg::edge_t   edge_i,
  output qcp_pkg::result_t result_o
);
  import qcp_pkg::*;

  localparam int unsigned RowW = (ROW_COUNT > 2) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned ColW = (COL_COUNT > 2) ? $clog2(COL_COUNT) : 1;
  localparam logic [RowW-1:0] RowLast = RowW'(ROW_COUNT - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(COL_COUNT - 1);
  localparam logic [RowW-1:0] RowHome = RowW'(ROW_COUNT / 2);
  localparam logic [ColW-1:0] ColHome = ColW'(COL_COUNT / 2);

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      left_q, left_d;
  logic [1:0]      right_q, right_d;

  logic              enc;
  logic              is_fall;
  logic              right_pin;
  logic              partner_flag;
  logic              step;
  logic              paint;
  logic [LevelW-1:0] r_sat, g_sat, b_sat;
  logic [ColorW-1:0] color;

  assign enc          = edge_i.encoder_select;
  assign is_fall      = (edge_i.cmd == CMD_LEFT_FALL) || (edge_i.cmd == CMD_RIGHT_FALL);
  assign right_pin    = (edge_i.cmd == CMD_RIGHT_FALL);
  assign partner_flag = right_pin ? left_q[enc] : right_q[enc];
  assign step         = is_fall && partner_flag;
  assign paint        = step && (edge_i.draw_mode || edge_i.erase_mode);

  // Palette color from saturated levels
  assign r_sat = level_sat(edge_i.red_level);
  assign g_sat = level_sat(edge_i.green_level);
  assign b_sat = level_sat(edge_i.blue_level);
  assign color = RedWeight * ColorW'(r_sat) + GrnWeight * ColorW'(g_sat)
               + ColorW'(b_sat) + ColorBase;

  // Next state: flag tracking and clamped cursor step
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    left_d  = left_q;
    right_d = right_q;
    if (!is_fall || step) begin
      left_d[enc]  = 1'b0;
      right_d[enc] = 1'b0;
    end else if (edge_i.partner_level) begin
      left_d[enc]  = !right_pin;
      right_d[enc] = right_pin;
    end
    if (step) begin
      if (!enc) begin
        if (right_pin) col_d = (col_q == ColLast) ? col_q : col_q + 1'b1;
        else           col_d = (col_q == '0) ? col_q : col_q - 1'b1;
      end else begin
        if (right_pin) row_d = (row_q == RowLast) ? row_q : row_q + 1'b1;
        else           row_d = (row_q == '0) ? row_q : row_q - 1'b1;
      end
    end
  end

  // Result as seen after the event
  always_comb begin
    result_o.moved        = step;
    result_o.cursor_row   = RowFieldW'(row_d);
    result_o.cursor_col   = ColFieldW'(col_d);
    result_o.write_enable = paint;
    result_o.write_color  = (paint && !edge_i.erase_mode) ? color : ColorBlack;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= RowHome;
      col_q   <= ColHome;
      left_q  <= '0;
      right_q <= '0;
    end else if (fire_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule
